// File: rtl/core/dpsr_pkg.sv
// Shared widths, register indexes and the sequencer control word of the dual PID regulator.
`timescale 1ns / 1ps

package dpsr_pkg;

  // Default values of the top-level parameters.
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int DRIVE_WIDTH_DEF    = 16;

  // Field widths.
  localparam int GAIN_W   = 16;
  localparam int SCALE_W  = 16;
  localparam int LIMIT_W  = 23;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int ERR_W    = 18;
  localparam int DIFF_W   = 19;
  localparam int SUM_W    = 24;
  localparam int ACC_W    = 42;
  localparam int SCALE_FRAC = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int BIT_CNT_W  = $clog2(GAIN_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_LEFT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_LEFT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_RIGHT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_RIGHT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_SCALE = 3'd7;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // Control word from the sequencer to both wheel datapaths.
  typedef struct packed {
    logic start;      // load target and scale, clear the accumulator
    logic step;       // one shift-add step of the serial multiplier
    logic gain_last;  // current multiplier bit is a signed gain's sign bit
    logic update;     // form error, integrator and difference, load kp
    logic load_i;     // load integrator and ki
    logic load_d;     // load difference and kd
  } dpsr_ctrl_t;

endpackage

// File: rtl/core/dpsr_wheel.sv
// One wheel's PID datapath built around a bit-serial shift-add multiplier.
`timescale 1ns / 1ps

module dpsr_wheel #(
  parameter int GAIN_FRAC_BITS = dpsr_pkg::GAIN_FRAC_BITS_DEF,
  parameter int DRIVE_WIDTH    = dpsr_pkg::DRIVE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dpsr_pkg::dpsr_ctrl_t                ctrl,
  input  logic signed [dpsr_pkg::IN_W-1:0]    target,
  input  logic signed [dpsr_pkg::IN_W-1:0]    count,
  input  logic signed [dpsr_pkg::GAIN_W-1:0]  kp,
  input  logic signed [dpsr_pkg::GAIN_W-1:0]  ki,
  input  logic signed [dpsr_pkg::GAIN_W-1:0]  kd,
  input  logic [dpsr_pkg::SCALE_W-1:0]        scale,
  input  logic [dpsr_pkg::LIMIT_W-1:0]        limit,
  output logic signed [dpsr_pkg::OUT_W-1:0]   drive,
  output logic                                clipped
);
  import dpsr_pkg::*;

  localparam logic signed [ACC_W-1:0] DMAX = ACC_W'((64'sd1 <<< (DRIVE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] DMIN = ACC_W'(-(64'sd1 <<< (DRIVE_WIDTH - 1)));

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  op;
  logic [GAIN_W-1:0]        mult;
  logic signed [IN_W-1:0]   count_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [DIFF_W-1:0] diff_r;

  logic signed [ACC_W-1:0]  addend;
  logic signed [25:0]       err_wide;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [SUM_W:0]    lim_pos;
  logic signed [SUM_W:0]    lim_neg;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;

  // Partial product of the current multiplier bit; a signed gain's top bit weighs negative.
  always_comb begin
    if (!mult[0]) begin
      addend = '0;
    end else if (ctrl.gain_last) begin
      addend = -op;
    end else begin
      addend = op;
    end
  end

  // Error from the scaled setpoint, saturated to the error width.
  always_comb begin
    err_wide = $signed({acc[32], acc[32:SCALE_FRAC]}) - $signed({{10{count_r[IN_W-1]}}, count_r});
    if (&err_wide[25:ERR_W-1] || ~|err_wide[25:ERR_W-1]) begin
      err = err_wide[ERR_W-1:0];
    end else if (err_wide[25]) begin
      err = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // Integrator: saturate to its width, then clamp to the windup bound.
  always_comb begin
    sum_wide = $signed({sum[SUM_W-1], sum}) + $signed({{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err});
    if (sum_wide[SUM_W] == sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W-1:0];
    end else if (sum_wide[SUM_W]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
    lim_pos = $signed({2'b00, limit});
    lim_neg = -lim_pos;
    if ($signed({sum_sat[SUM_W-1], sum_sat}) > lim_pos) begin
      sum_next = lim_pos[SUM_W-1:0];
    end else if ($signed({sum_sat[SUM_W-1], sum_sat}) < lim_neg) begin
      sum_next = lim_neg[SUM_W-1:0];
    end else begin
      sum_next = sum_sat;
    end
  end

  assign diff = $signed({err[ERR_W-1], err}) - $signed({last_err[ERR_W-1], last_err});

  // Serial multiplier, operand loads and the loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      last_err <= '0;
    end else if (ctrl.update) begin
      sum      <= sum_next;
      last_err <= err;
    end
    if (ctrl.start) begin
      acc     <= '0;
      op      <= {{(ACC_W-IN_W){target[IN_W-1]}}, target};
      mult    <= scale;
      count_r <= count;
    end else if (ctrl.update) begin
      acc    <= '0;
      op     <= {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
      mult   <= kp;
      diff_r <= diff;
    end else if (ctrl.load_i) begin
      op   <= {{(ACC_W-SUM_W){sum[SUM_W-1]}}, sum};
      mult <= ki;
    end else if (ctrl.load_d) begin
      op   <= {{(ACC_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
      mult <= kd;
    end else if (ctrl.step) begin
      acc  <= acc + addend;
      op   <= op <<< 1;
      mult <= mult >> 1;
    end
  end

  // Drop the gain fraction and saturate to the drive width.
  always_comb begin
    shifted = acc >>> GAIN_FRAC_BITS;
    fits    = &shifted[ACC_W-1:DRIVE_WIDTH-1] || ~|shifted[ACC_W-1:DRIVE_WIDTH-1];
    clipped = !fits;
    if (fits) begin
      drive = shifted[OUT_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      drive = DMIN[OUT_W-1:0];
    end else begin
      drive = DMAX[OUT_W-1:0];
    end
  end

endmodule

// File: rtl/core/dual_pid_speed_regulator_top.sv
// Top level of the two-wheel PID speed regulator: config registers, sequencer, output register.
//
//   Channel  Direction  Handshake              Word
//   in       input      in_valid / in_ready    target_left/right, count_left/right
//   out      output     out_valid / out_ready  drive_left/right, clipped_left/right
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// A word passes from acceptance to the output register through four passes of the bit-serial
// multiplier (setpoint scaling, then P, I and D) and the update, two load and finish states;
// the finish state waits while the output register is full, and no new word is taken before idle.
// Both wheels run in lockstep on one sequencer. The next word is accepted once the
// sequencer is idle, even while a result waits in the output register.
// Reset is synchronous; it clears the loop state and restores the config defaults.
`timescale 1ns / 1ps

module dual_pid_speed_regulator_top #(
  parameter int GAIN_FRAC_BITS = dpsr_pkg::GAIN_FRAC_BITS_DEF,
  parameter int DRIVE_WIDTH    = dpsr_pkg::DRIVE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dpsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpsr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dpsr_pkg::IN_W-1:0]      target_left,
  input  logic signed [dpsr_pkg::IN_W-1:0]      target_right,
  input  logic signed [dpsr_pkg::IN_W-1:0]      count_left,
  input  logic signed [dpsr_pkg::IN_W-1:0]      count_right,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dpsr_pkg::OUT_W-1:0]     drive_left,
  output logic signed [dpsr_pkg::OUT_W-1:0]     drive_right,
  output logic                                  clipped_left,
  output logic                                  clipped_right
);
  import dpsr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCALE  = 9'b000000010,
    S_UPDATE = 9'b000000100,
    S_MUL_P  = 9'b000001000,
    S_LOAD_I = 9'b000010000,
    S_MUL_I  = 9'b000100000,
    S_LOAD_D = 9'b001000000,
    S_MUL_D  = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic                   cnt_done;
  logic                   out_load;
  dpsr_ctrl_t             ctrl;

  logic signed [GAIN_W-1:0] kp_left;
  logic signed [GAIN_W-1:0] ki_left;
  logic signed [GAIN_W-1:0] kd_left;
  logic signed [GAIN_W-1:0] kp_right;
  logic signed [GAIN_W-1:0] ki_right;
  logic signed [GAIN_W-1:0] kd_right;
  logic [LIMIT_W-1:0]       windup_limit;
  logic [SCALE_W-1:0]       setpoint_scale;

  logic signed [OUT_W-1:0]  drive_l;
  logic signed [OUT_W-1:0]  drive_r;
  logic                     clip_l;
  logic                     clip_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_left        <= '0;
      ki_left        <= '0;
      kd_left        <= '0;
      kp_right       <= '0;
      ki_right       <= '0;
      kd_right       <= '0;
      windup_limit   <= '0;
      setpoint_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_LEFT:        kp_left        <= cfg_data[GAIN_W-1:0];
        REG_KI_LEFT:        ki_left        <= cfg_data[GAIN_W-1:0];
        REG_KD_LEFT:        kd_left        <= cfg_data[GAIN_W-1:0];
        REG_KP_RIGHT:       kp_right       <= cfg_data[GAIN_W-1:0];
        REG_KI_RIGHT:       ki_right       <= cfg_data[GAIN_W-1:0];
        REG_KD_RIGHT:       kd_right       <= cfg_data[GAIN_W-1:0];
        REG_WINDUP_LIMIT:   windup_limit   <= cfg_data[LIMIT_W-1:0];
        REG_SETPOINT_SCALE: setpoint_scale <= cfg_data[SCALE_W-1:0];
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign cnt_done = (bit_cnt == BIT_CNT_W'(GAIN_W - 1));
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCALE;
      S_SCALE:  if (cnt_done) state_next = S_UPDATE;
      S_UPDATE: state_next = S_MUL_P;
      S_MUL_P:  if (cnt_done) state_next = S_LOAD_I;
      S_LOAD_I: state_next = S_MUL_I;
      S_MUL_I:  if (cnt_done) state_next = S_LOAD_D;
      S_LOAD_D: state_next = S_MUL_D;
      S_MUL_D:  if (cnt_done) state_next = S_FINISH;
      S_FINISH: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control word for both wheels.
  always_comb begin
    ctrl.start     = in_valid && in_ready;
    ctrl.step      = (state == S_SCALE) || (state == S_MUL_P) ||
                     (state == S_MUL_I) || (state == S_MUL_D);
    ctrl.gain_last = cnt_done && (state != S_SCALE);
    ctrl.update    = (state == S_UPDATE);
    ctrl.load_i    = (state == S_LOAD_I);
    ctrl.load_d    = (state == S_LOAD_D);
  end

  // Sequencer state and multiplier bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
    end else begin
      state <= state_next;
      if (ctrl.step) begin
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end else begin
        bit_cnt <= '0;
      end
    end
  end

  dpsr_wheel #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DRIVE_WIDTH    (DRIVE_WIDTH)
  ) u_wheel_left (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .target  (target_left),
    .count   (count_left),
    .kp      (kp_left),
    .ki      (ki_left),
    .kd      (kd_left),
    .scale   (setpoint_scale),
    .limit   (windup_limit),
    .drive   (drive_l),
    .clipped (clip_l)
  );

  dpsr_wheel #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DRIVE_WIDTH    (DRIVE_WIDTH)
  ) u_wheel_right (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .target  (target_right),
    .count   (count_right),
    .kp      (kp_right),
    .ki      (ki_right),
    .kd      (kd_right),
    .scale   (setpoint_scale),
    .limit   (windup_limit),
    .drive   (drive_r),
    .clipped (clip_r)
  );

  // Output register holds the finished word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      drive_left    <= drive_l;
      drive_right   <= drive_r;
      clipped_left  <= clip_l;
      clipped_right <= clip_r;
    end
  end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the dual PID speed regulator: stimulus, handshakes and a predictor.
`timescale 1ns / 1ps

module tb;
  import dpsr_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 212;

  localparam longint IN_HI  = (longint'(1) <<< (IN_W - 1)) - 1;
  localparam longint IN_LO  = -IN_HI - 1;
  localparam longint ERR_HI = (longint'(1) <<< (ERR_W - 1)) - 1;
  localparam longint ERR_LO = -ERR_HI - 1;
  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint DRV_HI = (longint'(1) <<< (DRIVE_WIDTH_DEF - 1)) - 1;
  localparam longint DRV_LO = -DRV_HI - 1;
  localparam int     LIMIT_MAX = (1 << LIMIT_W) - 1;
  localparam int     SCALE_MAX = (1 << SCALE_W) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{REG_KP_LEFT, REG_KI_LEFT, REG_KD_LEFT,
    REG_KP_RIGHT, REG_KI_RIGHT, REG_KD_RIGHT, REG_WINDUP_LIMIT, REG_SETPOINT_SCALE};

  typedef struct packed {
    logic signed [OUT_W-1:0] drive_left;
    logic signed [OUT_W-1:0] drive_right;
    logic                    clipped_left;
    logic                    clipped_right;
  } drive_word_t;

  // Predicts the drive word of each accepted setpoint word and checks the results in order.
  class pid_scoreboard;
    drive_word_t expected_drives[$];
    int errors;
    logic signed [GAIN_W-1:0] kp[2], ki[2], kd[2];
    logic [LIMIT_W-1:0] windup_limit;
    logic [SCALE_W-1:0] scale;
    logic signed [SUM_W-1:0] integ[2];
    logic signed [ERR_W-1:0] last_err[2];

    function new();
      int w;
      errors = 0;
      windup_limit = '0;
      scale = SCALE_RESET;
      for (w = 0; w < 2; w++) begin
        kp[w] = '0;
        ki[w] = '0;
        kd[w] = '0;
        integ[w] = '0;
        last_err[w] = '0;
      end
    endfunction

    function longint bound(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KP_LEFT:        kp[0] = data[GAIN_W-1:0];
        REG_KI_LEFT:        ki[0] = data[GAIN_W-1:0];
        REG_KD_LEFT:        kd[0] = data[GAIN_W-1:0];
        REG_KP_RIGHT:       kp[1] = data[GAIN_W-1:0];
        REG_KI_RIGHT:       ki[1] = data[GAIN_W-1:0];
        REG_KD_RIGHT:       kd[1] = data[GAIN_W-1:0];
        REG_WINDUP_LIMIT:   windup_limit = data[LIMIT_W-1:0];
        REG_SETPOINT_SCALE: scale = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // One PID update of one wheel; advances that wheel's integrator and previous error.
    function void step_wheel(int w, logic signed [IN_W-1:0] target,
                             logic signed [IN_W-1:0] count,
                             output logic signed [OUT_W-1:0] drive, output logic clipped);
      longint err, sum, diff, acc, q, lim;
      err = ((longint'(target) * longint'(scale)) >>> SCALE_FRAC) - longint'(count);
      err = bound(err, ERR_LO, ERR_HI);
      lim = longint'(windup_limit);
      sum = bound(longint'(integ[w]) + err, SUM_LO, SUM_HI);
      sum = bound(sum, -lim, lim);
      diff = err - longint'(last_err[w]);
      acc = longint'(kp[w]) * err + longint'(ki[w]) * sum + longint'(kd[w]) * diff;
      q = acc >>> GAIN_FRAC_BITS_DEF;
      clipped = (q > DRV_HI) || (q < DRV_LO);
      drive = OUT_W'(bound(q, DRV_LO, DRV_HI));
      integ[w] = SUM_W'(sum);
      last_err[w] = ERR_W'(err);
    endfunction

    function void note_word(logic signed [IN_W-1:0] tl, logic signed [IN_W-1:0] tr,
                            logic signed [IN_W-1:0] cl, logic signed [IN_W-1:0] cr);
      drive_word_t e;
      step_wheel(0, tl, cl, e.drive_left, e.clipped_left);
      step_wheel(1, tr, cr, e.drive_right, e.clipped_right);
      expected_drives.push_back(e);
    endfunction

    function void compare_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_word(drive_word_t got);
      drive_word_t e;
      if (expected_drives.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual %0d %0d %0d %0d",
                 $time, got.drive_left, got.drive_right, got.clipped_left, got.clipped_right);
        errors++;
        return;
      end
      e = expected_drives.pop_front();
      compare_field("drive_left", e.drive_left, got.drive_left);
      compare_field("drive_right", e.drive_right, got.drive_right);
      compare_field("clipped_left", e.clipped_left, got.clipped_left);
      compare_field("clipped_right", e.clipped_right, got.clipped_right);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KP_LEFT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] target_left = '0;
  logic signed [IN_W-1:0] target_right = '0;
  logic signed [IN_W-1:0] count_left = '0;
  logic signed [IN_W-1:0] count_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] drive_left;
  logic signed [OUT_W-1:0] drive_right;
  logic clipped_left;
  logic clipped_right;

  pid_scoreboard sb;
  int send_idle;
  int recv_idle;
  logic [SCALE_W-1:0] cur_scale;

  dual_pid_speed_regulator_top dut (.*);

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #40_000_000;
    $display("dual_pid_speed_regulator_top regression: fail");
    $finish;
  end

  function automatic logic signed [IN_W-1:0] sat16(longint v);
    if (v > IN_HI) return IN_HI[IN_W-1:0];
    if (v < IN_LO) return IN_LO[IN_W-1:0];
    return v[IN_W-1:0];
  endfunction

  function automatic int jitter(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic longint scaled(logic signed [IN_W-1:0] t);
    return (longint'(t) * longint'(cur_scale)) >>> SCALE_FRAC;
  endfunction

  // Field values lean toward the extremes and toward small magnitudes.
  function automatic logic signed [IN_W-1:0] pick_field();
    case ($urandom_range(7))
      0: return IN_HI[IN_W-1:0];
      1: return IN_LO[IN_W-1:0];
      2: return sat16(longint'(jitter(64)));
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(3))
      0: return jitter(512);
      1: return int'($urandom_range(0, 65535)) - 32768;
      2: return $urandom_range(1) ? 32767 : -32768;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(3))
      0: return 0;
      1: return $urandom_range(0, 2000);
      2: return $urandom_range(0, LIMIT_MAX);
      default: return LIMIT_MAX;
    endcase
  endfunction

  function automatic int pick_scale();
    case ($urandom_range(3))
      0: return 256;
      1: return $urandom_range(0, SCALE_MAX);
      2: return $urandom_range(0, 600);
      default: return SCALE_MAX;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] gain_word(int g);
    logic [GAIN_W-1:0] g16;
    g16 = GAIN_W'(g);
    return CFG_DATA_W'(g16);
  endfunction

  // Writes all eight registers on consecutive edges; the block must be idle.
  task automatic program_regs(int kpl, int kil, int kdl, int kpr, int kir, int kdr,
                              int lim, int scl);
    logic [CFG_DATA_W-1:0] plan [8];
    int i;
    plan[REG_KP_LEFT] = gain_word(kpl);
    plan[REG_KI_LEFT] = gain_word(kil);
    plan[REG_KD_LEFT] = gain_word(kdl);
    plan[REG_KP_RIGHT] = gain_word(kpr);
    plan[REG_KI_RIGHT] = gain_word(kir);
    plan[REG_KD_RIGHT] = gain_word(kdr);
    plan[REG_WINDUP_LIMIT] = CFG_DATA_W'(lim);
    plan[REG_SETPOINT_SCALE] = CFG_DATA_W'(scl);
    cur_scale = SCALE_W'(scl);
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data <= plan[REG_ORDER[i]];
      @(posedge clk);
      sb.write_reg(REG_ORDER[i], plan[REG_ORDER[i]]);
    end
    cfg_we <= 1'b0;
  endtask

  // Presents one setpoint word and returns at the edge where it is accepted.
  // Valid is left high so the next word can follow back to back.
  task automatic send_word(logic signed [IN_W-1:0] tl, logic signed [IN_W-1:0] tr,
                           logic signed [IN_W-1:0] cl, logic signed [IN_W-1:0] cr);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle)
      gap = $urandom_range(1, 90);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target_left <= tl;
    target_right <= tr;
    count_left <= cl;
    count_right <= cr;
    do @(posedge clk); while (!in_ready);
    sb.note_word(tl, tr, cl, cr);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.expected_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: check each accepted word, then choose ready for the next edge.
  initial begin : result_sink
    drive_word_t got;
    int hold;
    hold = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.drive_left = drive_left;
        got.drive_right = drive_right;
        got.clipped_left = clipped_left;
        got.clipped_right = clipped_right;
        sb.check_word(got);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (recv_idle > 0 && $urandom_range(199) == 0) begin
        hold = $urandom_range(20, 150);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin : stimulus
    int p, n, k, kind, seq_len, dir;
    bit paused;
    logic signed [IN_W-1:0] tl, tr, cl, cr;
    sb = new();
    cur_scale = SCALE_RESET;
    send_idle = 32;
    recv_idle = 61;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: zero gains and a zero windup limit give zero drives.
    send_word(IN_HI[IN_W-1:0], IN_LO[IN_W-1:0], IN_LO[IN_W-1:0], IN_HI[IN_W-1:0]);
    send_word(0, 0, 0, 0);

    // Unity proportional gain with the integrator held at zero by a zero limit.
    stop_sending();
    wait_idle();
    program_regs(256, 300, 0, 256, -300, 0, 0, 256);
    send_word(IN_HI[IN_W-1:0], IN_LO[IN_W-1:0], IN_LO[IN_W-1:0], IN_HI[IN_W-1:0]);
    send_word(100, -100, 40, -40);
    send_word(-1, 1, 0, 0);
    send_word(0, 0, 0, 0);

    // Largest scale: the error saturates, then swings end to end for the derivative.
    stop_sending();
    wait_idle();
    program_regs(1, 256, 256, -32768, 32767, -1, LIMIT_MAX, SCALE_MAX);
    send_word(IN_HI[IN_W-1:0], IN_LO[IN_W-1:0], IN_LO[IN_W-1:0], IN_HI[IN_W-1:0]);
    send_word(IN_LO[IN_W-1:0], IN_HI[IN_W-1:0], IN_HI[IN_W-1:0], IN_LO[IN_W-1:0]);
    send_word(1, -1, 0, 0);
    send_word(0, 0, 0, 0);

    // Zero scale: the error is the negated count alone, with a tiny windup limit.
    stop_sending();
    wait_idle();
    program_regs(32767, 128, 0, 32767, -128, 0, 5, 0);
    send_word(IN_HI[IN_W-1:0], IN_LO[IN_W-1:0], IN_LO[IN_W-1:0], IN_HI[IN_W-1:0]);
    send_word(0, 0, 1, -1);

    // Random phases: each picks a register set and an idling pattern.
    for (p = 0; p < PHASES; p++) begin
      stop_sending();
      wait_idle();
      case (p / 3)
        0: begin
          send_idle = 32;
          recv_idle = 61;
        end
        1: begin
          send_idle = 61;
          recv_idle = 32;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (p == 0)
        program_regs(32767, 32767, 32767, 32767, 32767, 32767, LIMIT_MAX, SCALE_MAX);
      else if (p == 1)
        program_regs(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0);
      else
        program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                     pick_gain(), pick_limit(), pick_scale());
      n = 0;
      while (n < PHASE_WORDS) begin
        kind = $urandom_range(29);
        if (kind == 0) begin
          // Windup run: opposite extremes push both integrators into their limits.
          seq_len = $urandom_range(60, 140);
          dir = $urandom_range(1);
          for (k = 0; k < seq_len; k++) begin
            tl = dir ? IN_HI[IN_W-1:0] : IN_LO[IN_W-1:0];
            tr = dir ? IN_LO[IN_W-1:0] : IN_HI[IN_W-1:0];
            cl = sat16((dir ? IN_LO : IN_HI) + longint'(jitter(8)));
            cr = sat16((dir ? IN_HI : IN_LO) + longint'(jitter(8)));
            send_word(tl, tr, cl, cr);
            n++;
          end
        end else if (kind < 6) begin
          // Unrelated words.
          seq_len = $urandom_range(1, 8);
          for (k = 0; k < seq_len; k++) begin
            send_word(pick_field(), pick_field(), pick_field(), pick_field());
            n++;
          end
        end else begin
          // Closed-loop tracking: counts follow the scaled setpoint with noise.
          seq_len = $urandom_range(8, 40);
          tl = pick_field();
          tr = pick_field();
          for (k = 0; k < seq_len; k++) begin
            tl = sat16(longint'(tl) + longint'(jitter(3)));
            tr = sat16(longint'(tr) + longint'(jitter(3)));
            cl = sat16(scaled(tl) + longint'(jitter(24)));
            cr = sat16(scaled(tr) + longint'(jitter(24)));
            send_word(tl, tr, cl, cr);
            n++;
          end
        end
        // Once, hold the input off until every result has come back.
        if (p == 4 && !paused && n >= 100) begin
          paused = 1'b1;
          stop_sending();
          wait_idle();
        end
      end
    end

    stop_sending();
    send_idle = 0;
    recv_idle = 0;
    wait_idle();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.expected_drives.size() == 0) begin
      $display("dual_pid_speed_regulator_top regression: pass");
    end else begin
      $display("dual_pid_speed_regulator_top regression: fail");
    end
    $finish;
  end

endmodule
